// ===== rtl/core/float_format_converter_core_macros.svh =====
// Assertion macros shared by the converter RTL
`ifndef FLOAT_FORMAT_CONVERTER_CORE_MACROS_SVH
`define FLOAT_FORMAT_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while in reset
`define FFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, ignored while in reset
`define FFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/ffc_pkg.sv =====
// Package: conversion codes, format constants and conversion functions
`timescale 1ns / 1ps
`default_nettype none

package ffc_pkg;

    typedef enum logic [2:0] {
        MODE_BF16_TO_FP32 = 3'd0,
        MODE_FP32_TO_BF16 = 3'd1,
        MODE_FP16_TO_FP32 = 3'd2,
        MODE_FP32_TO_FP16 = 3'd3,
        MODE_FP16_TO_BF16 = 3'd4,
        MODE_BF16_TO_FP16 = 3'd5
    } mode_t;

    localparam logic [31:0] BF16_ROUND  = 32'h0000_8000;
    localparam logic [31:0] FP32_INF    = 32'h7F80_0000;
    localparam logic [15:0] FP16_INF    = 16'h7C00;
    localparam logic [23:0] HALF_RBIT   = 24'h00_1000;
    localparam logic [23:0] HALF_RINC   = 24'h00_2000;
    localparam logic [23:0] FP32_HIDDEN = 24'h80_0000;
    localparam logic [7:0]  BIAS_DELTA  = 8'd112;   // 127 - 15

    // Leading zeros of a 10-bit fp16 mantissa (input known non-zero)
    function automatic logic [3:0] lzc10(input logic [9:0] m);
        logic [3:0] n;
        logic       found;
        n     = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                n     = 4'(9 - i);
            end
        end
        return n;
    endfunction

    // fp16 -> fp32, exact
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] sh;
        logic [7:0]  eb;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        lz  = lzc10(man);
        sh  = {1'b0, man} << (lz + 4'd1);
        eb  = BIAS_DELTA - {4'd0, lz};
        if (ex == 5'd0) begin
            if (man == 10'd0)
                r = {h[15], 31'd0};
            else
                r = {h[15], eb, sh[9:0], 13'd0};
        end else if (ex == 5'h1F) begin
            r = {h[15], 31'd0} | FP32_INF | {9'd0, man, 13'd0};
        end else begin
            r = {h[15], {3'd0, ex} + BIAS_DELTA, man, 13'd0};
        end
        return r;
    endfunction

    // fp32 -> bf16: add half an lsb, keep the top half (32-bit wrap)
    function automatic logic [15:0] narrow_to_bf16(input logic [31:0] x);
        logic [31:0] s;
        s = x + BF16_ROUND;
        return s[31:16];
    endfunction

    // fp32 -> fp16 with round on bit 12, subnormals, flush and overflow
    function automatic logic [15:0] narrow_to_half(input logic [31:0] x);
        logic [7:0]  e8;
        logic [23:0] m;
        logic [3:0]  shamt;
        logic [7:0]  exn;
        logic [14:0] mag;
        logic [15:0] r;
        e8    = x[30:23];
        shamt = 4'd0;
        exn   = 8'd0;
        mag   = 15'd0;
        m     = {1'b0, x[22:0]};
        if (e8 < 8'd102) begin
            r = {x[31], 15'd0};
        end else if (e8 <= BIAS_DELTA) begin
            // subnormal: shift in the hidden one, then round
            exn   = 8'd113 - e8;
            shamt = exn[3:0];
            m     = (m | FP32_HIDDEN) >> shamt;
            if ((m & HALF_RBIT) != 24'd0)
                m = m + HALF_RINC;
            r = {x[31], 4'd0, m[23:13]};
        end else if (e8 >= 8'd143) begin
            r = {x[31], 15'd0} | FP16_INF;
        end else begin
            // normal: the rounding carry runs into the exponent
            exn = e8 - BIAS_DELTA;
            if ((m & HALF_RBIT) != 24'd0)
                m = m + HALF_RINC;
            mag = {exn[4:0], 10'd0} + {4'd0, m[23:13]};
            r   = {x[31], mag};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/float_format_converter_core.sv =====
// Top level: fp32 / fp16 / bf16 bit-pattern converter, two register stages
`timescale 1ns / 1ps
`default_nettype none

//  channel   | ports                  | handshake
//  ----------+------------------------+----------------------------------
//  command   | start, mode, operand   | taken when start is high, busy low
//  result    | done, result           | one-cycle strobe, cannot be held
//
//  An accepted word sits in the input register while the conversion logic
//  works on it, and the next edge loads the result register and raises
//  done for one cycle. A new word is taken every cycle, so throughput is one
//  per cycle. busy is never raised; nothing downstream can stall the pipeline.
//  Reset clears both valid flags; payload registers are left as they are.

module float_format_converter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] operand,
    output logic             done,
    output logic [31:0]      result
);

    // input stage
    logic        valid_reg;
    logic [2:0]  mode_reg;
    logic [31:0] operand_reg;

    // result stage
    logic        done_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    // shared intermediates
    logic [15:0] lo;
    logic [31:0] widened;
    logic [31:0] bf_src;
    logic [31:0] half_src;
    logic [15:0] bf_word;
    logic [15:0] half_word;
    logic        narrow_mode;

    // the pipeline never stalls
    assign busy = 1'b0;

    // register the accepted word in the input stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            mode_reg    <= mode;
            operand_reg <= operand;
        end
    end

    // One widener and one of each narrower, shared by the direct and the
    // chained conversions; the mode only picks their sources.
    assign lo       = operand_reg[15:0];
    assign widened  = ffc_pkg::widen_half(lo);
    assign bf_src   = (mode_reg == ffc_pkg::MODE_FP16_TO_BF16) ? widened : operand_reg;
    assign half_src = (mode_reg == ffc_pkg::MODE_BF16_TO_FP16) ? {lo, 16'd0} : operand_reg;
    assign bf_word   = ffc_pkg::narrow_to_bf16(bf_src);
    assign half_word = ffc_pkg::narrow_to_half(half_src);

    always_comb begin
        unique case (mode_reg)
            ffc_pkg::MODE_BF16_TO_FP32: result_next = {lo, 16'd0};
            ffc_pkg::MODE_FP32_TO_BF16: result_next = {16'd0, bf_word};
            ffc_pkg::MODE_FP16_TO_FP32: result_next = widened;
            ffc_pkg::MODE_FP32_TO_FP16: result_next = {16'd0, half_word};
            ffc_pkg::MODE_FP16_TO_BF16: result_next = {16'd0, bf_word};
            ffc_pkg::MODE_BF16_TO_FP16: result_next = {16'd0, half_word};
            default:                    result_next = 32'd0;  // unused codes
        endcase
    end

    // advance the converted word into the result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // conversions whose target is a 16-bit format
    assign narrow_mode = (mode_reg == ffc_pkg::MODE_FP32_TO_BF16)
                      || (mode_reg == ffc_pkg::MODE_FP32_TO_FP16)
                      || (mode_reg == ffc_pkg::MODE_FP16_TO_BF16)
                      || (mode_reg == ffc_pkg::MODE_BF16_TO_FP16);

`include "float_format_converter_core_macros.svh"

    // an accepted word reaches the input stage, then the result strobe
    `FFC_ASSERT_NEXT(a_accept_to_stage, start && !busy, valid_reg)
    `FFC_ASSERT_NEXT(a_stage_to_done, valid_reg, done)
    // 16-bit targets leave the upper half clear
    `FFC_ASSERT_NEXT(a_narrow_upper_zero, valid_reg && narrow_mode, result[31:16] == 16'd0)

endmodule

`default_nettype wire
